// ===== hdl/alt_pkg.sv =====
`default_nettype none

package alt_pkg;

   localparam int ACC_W           = 26;
   localparam int COUNT_W         = 11;
   localparam int ITEM_IDX_W      = 10;
   localparam int AGENT_IDX_W     = 6;
   localparam int WEIGHT_IN_W     = 16;
   localparam int COST_W          = 16;

   localparam int DEF_MAX_ITEMS   = 1024;
   localparam int DEF_MAX_AGENTS  = 64;
   localparam int DEF_WEIGHT_BITS = 16;

   localparam logic REQ_ASSIGN    = 1'b0;
   localparam logic REQ_CAPACITY  = 1'b1;

   typedef logic [ACC_W-1:0]   acc_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      acc_type capacity;
      acc_type weight;
      acc_type cost;
      acc_type overcap;
   } agent_rec_type;

   typedef struct packed {
      acc_type   cost;
      acc_type   weight;
      acc_type   overcap;
      count_type count;
   } sums_type;

   typedef enum logic [1:0] {
      CALC_NONE,
      CALC_ADD,
      CALC_REMOVE,
      CALC_CAPACITY
   } calc_op_type;

endpackage

`default_nettype wire

// ===== hdl/alt_ram.sv =====
`default_nettype none

module alt_ram #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/alt_calc.sv =====
`default_nettype none

module alt_calc (
   input  wire alt_pkg::calc_op_type   op,
   input  wire alt_pkg::agent_rec_type rec_i,
   input  wire alt_pkg::acc_type       weight,
   input  wire alt_pkg::acc_type       cost,
   input  wire alt_pkg::acc_type       capacity,
   input  wire alt_pkg::sums_type      sums_i,
   output alt_pkg::agent_rec_type      rec_o,
   output alt_pkg::sums_type           sums_o
);

   import alt_pkg::*;

   acc_type          drop;
   acc_type          rise;
   acc_type          oc_new;
   logic [ACC_W:0]   sum_wide;

   always_comb begin
      drop     = '0;
      rise     = '0;
      oc_new   = '0;
      sum_wide = {1'b0, rec_i.weight} + {1'b0, weight};

      // clipped excess: only the part above capacity moves overcapacity
      if (rec_i.weight <= rec_i.capacity) begin
         drop = '0;
      end else if (rec_i.weight >= weight && (rec_i.weight - weight) >= rec_i.capacity) begin
         drop = weight;
      end else begin
         drop = rec_i.weight - rec_i.capacity;
      end

      if (rec_i.weight >= rec_i.capacity) begin
         rise = weight;
      end else if (sum_wide <= {1'b0, rec_i.capacity}) begin
         rise = '0;
      end else begin
         rise = ACC_W'(sum_wide - {1'b0, rec_i.capacity});
      end

      if (rec_i.weight > capacity) begin
         oc_new = rec_i.weight - capacity;
      end

      rec_o  = rec_i;
      sums_o = sums_i;
      case (op)
         CALC_ADD: begin
            rec_o.overcap  = rec_i.overcap + rise;
            rec_o.cost     = rec_i.cost + cost;
            rec_o.weight   = rec_i.weight + weight;
            sums_o.overcap = sums_i.overcap + rise;
            sums_o.cost    = sums_i.cost + cost;
            sums_o.weight  = sums_i.weight + weight;
            sums_o.count   = sums_i.count + COUNT_W'(1);
         end
         CALC_REMOVE: begin
            rec_o.overcap  = rec_i.overcap - drop;
            rec_o.cost     = rec_i.cost - cost;
            rec_o.weight   = rec_i.weight - weight;
            sums_o.overcap = sums_i.overcap - drop;
            sums_o.cost    = sums_i.cost - cost;
            sums_o.weight  = sums_i.weight - weight;
            sums_o.count   = sums_i.count - COUNT_W'(1);
         end
         CALC_CAPACITY: begin
            rec_o.capacity = capacity;
            rec_o.overcap  = oc_new;
            sums_o.overcap = sums_i.overcap - rec_i.overcap + oc_new;
         end
         default: begin
            rec_o  = rec_i;
            sums_o = sums_i;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/assignment_load_tracker.sv =====
`default_nettype none

// Capacity requests and requests that change nothing pass through S_FETCH to the result strobe.
// Assigning a free item passes through S_FETCH and S_ADD, unassigning through S_FETCH and S_REMOVE;
// moving an item between agents through S_FETCH, S_REMOVE and S_ADD. Each state reads or writes
// the item or agent memory; the next request is taken in the cycle of the result strobe. The
// receiver cannot stall results. After reset busy stays high while S_CLEAR clears both memories.
module assignment_load_tracker #(
   parameter int MAX_ITEMS   = alt_pkg::DEF_MAX_ITEMS,
   parameter int MAX_AGENTS  = alt_pkg::DEF_MAX_AGENTS,
   parameter int WEIGHT_BITS = alt_pkg::DEF_WEIGHT_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_type,
   input  wire logic [alt_pkg::ITEM_IDX_W-1:0]  req_item_index,
   input  wire logic [alt_pkg::AGENT_IDX_W-1:0] req_agent_index,
   input  wire logic                            req_unassign,
   input  wire logic [alt_pkg::WEIGHT_IN_W-1:0] req_item_weight,
   input  wire logic [alt_pkg::COST_W-1:0]      req_item_cost,
   input  wire logic [alt_pkg::ACC_W-1:0]       req_capacity_value,
   output logic                                 rsp_valid,
   output logic [alt_pkg::ACC_W-1:0]            rsp_total_cost,
   output logic [alt_pkg::ACC_W-1:0]            rsp_total_weight,
   output logic [alt_pkg::ACC_W-1:0]            rsp_total_overcapacity,
   output logic [alt_pkg::COUNT_W-1:0]          rsp_assigned_count,
   output logic                                 rsp_feasible,
   output logic [alt_pkg::ACC_W-1:0]            rsp_agent_load
);

   import alt_pkg::*;

   localparam int ITEM_AW   = $clog2(MAX_ITEMS);
   localparam int AGENT_AW  = $clog2(MAX_AGENTS);
   localparam int CLR_DEPTH = (MAX_ITEMS > MAX_AGENTS) ? MAX_ITEMS : MAX_AGENTS;
   localparam int CLR_W     = $clog2(CLR_DEPTH);

   typedef struct packed {
      logic                   valid;
      logic [AGENT_AW-1:0]    agent;
      logic [WEIGHT_BITS-1:0] weight;
      logic [COST_W-1:0]      cost;
   } item_rec_type;

   localparam int ITEM_W  = $bits(item_rec_type);
   localparam int AGENT_W = $bits(agent_rec_type);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_REMOVE,
      S_ADD
   } state_type;

   state_type              state_ff, state_in;
   logic [CLR_W-1:0]       clr_ff, clr_in;
   logic                   type_ff, type_in;
   logic [ITEM_AW-1:0]     item_ff, item_in;
   logic [AGENT_AW-1:0]    agent_ff, agent_in;
   logic                   item_ok_ff, item_ok_in;
   logic                   agent_ok_ff, agent_ok_in;
   logic                   unassign_ff, unassign_in;
   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic [COST_W-1:0]      cost_ff, cost_in;
   acc_type                capv_ff, capv_in;
   agent_rec_type          nrec_ff, nrec_in;
   sums_type               sums_ff, sums_in;
   acc_type                load_ff, load_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   accept;
   item_rec_type           item_rd;
   item_rec_type           item_wdata;
   logic                   item_we;
   logic [ITEM_AW-1:0]     item_waddr;
   agent_rec_type          agent_rd;
   agent_rec_type          agent_wdata;
   logic                   agent_we;
   logic [AGENT_AW-1:0]    agent_waddr;
   logic                   agent_re;
   logic [AGENT_AW-1:0]    agent_raddr;

   calc_op_type            calc_op;
   agent_rec_type          calc_rec;
   acc_type                calc_weight;
   acc_type                calc_cost;
   agent_rec_type          calc_rec_out;
   sums_type               calc_sums_out;

   assign accept = start && (state_ff == S_IDLE);

   alt_ram #(
      .DEPTH (MAX_ITEMS),
      .WIDTH (ITEM_W)
   ) u_item_ram (
      .clock   (clock),
      .wr_en   (item_we),
      .wr_addr (item_waddr),
      .wr_data (item_wdata),
      .rd_en   (accept),
      .rd_addr (ITEM_AW'(req_item_index)),
      .rd_data (item_rd)
   );

   alt_ram #(
      .DEPTH (MAX_AGENTS),
      .WIDTH (AGENT_W)
   ) u_agent_ram (
      .clock   (clock),
      .wr_en   (agent_we),
      .wr_addr (agent_waddr),
      .wr_data (agent_wdata),
      .rd_en   (agent_re),
      .rd_addr (agent_raddr),
      .rd_data (agent_rd)
   );

   alt_calc u_calc (
      .op       (calc_op),
      .rec_i    (calc_rec),
      .weight   (calc_weight),
      .cost     (calc_cost),
      .capacity (capv_ff),
      .sums_i   (sums_ff),
      .rec_o    (calc_rec_out),
      .sums_o   (calc_sums_out)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      type_in      = type_ff;
      item_in      = item_ff;
      agent_in     = agent_ff;
      item_ok_in   = item_ok_ff;
      agent_ok_in  = agent_ok_ff;
      unassign_in  = unassign_ff;
      weight_in    = weight_ff;
      cost_in      = cost_ff;
      capv_in      = capv_ff;
      nrec_in      = nrec_ff;
      sums_in      = sums_ff;
      load_in      = load_ff;
      rsp_valid_in = 1'b0;

      item_we      = 1'b0;
      item_waddr   = item_ff;
      item_wdata   = item_rd;
      agent_we     = 1'b0;
      agent_waddr  = agent_ff;
      agent_wdata  = calc_rec_out;
      agent_re     = 1'b0;
      agent_raddr  = AGENT_AW'(req_agent_index);

      calc_op      = CALC_NONE;
      calc_rec     = agent_rd;
      calc_weight  = ACC_W'(weight_ff);
      calc_cost    = ACC_W'(cost_ff);

      case (state_ff)
         S_CLEAR: begin
            item_we     = (32'(clr_ff) < MAX_ITEMS);
            item_waddr  = ITEM_AW'(clr_ff);
            item_wdata  = '0;
            agent_we    = (32'(clr_ff) < MAX_AGENTS);
            agent_waddr = AGENT_AW'(clr_ff);
            agent_wdata = '0;
            clr_in      = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_W'(CLR_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               agent_re    = 1'b1;
               type_in     = req_type;
               item_in     = ITEM_AW'(req_item_index);
               agent_in    = AGENT_AW'(req_agent_index);
               item_ok_in  = (32'(req_item_index) < MAX_ITEMS);
               agent_ok_in = (32'(req_agent_index) < MAX_AGENTS);
               unassign_in = req_unassign;
               weight_in   = WEIGHT_BITS'(req_item_weight);
               cost_in     = req_item_cost;
               capv_in     = req_capacity_value;
               state_in    = S_FETCH;
            end
         end
         S_FETCH: begin
            // fetch the current agent of the item in case it must be removed
            agent_re    = 1'b1;
            agent_raddr = item_rd.agent;
            nrec_in     = agent_rd;
            load_in     = '0;
            state_in    = S_IDLE;
            if (type_ff == REQ_CAPACITY) begin
               if (agent_ok_ff) begin
                  calc_op  = CALC_CAPACITY;
                  agent_we = 1'b1;
                  sums_in  = calc_sums_out;
                  load_in  = agent_rd.weight;
               end
            end else if (item_ok_ff) begin
               if (unassign_ff) begin
                  if (item_rd.valid) begin
                     state_in = S_REMOVE;
                  end
               end else if (agent_ok_ff) begin
                  if (item_rd.valid && item_rd.agent == agent_ff) begin
                     load_in = agent_rd.weight;
                  end else if (item_rd.valid) begin
                     state_in = S_REMOVE;
                  end else begin
                     state_in = S_ADD;
                  end
               end
            end
            rsp_valid_in = (state_in == S_IDLE);
         end
         S_REMOVE: begin
            calc_op          = CALC_REMOVE;
            calc_weight      = ACC_W'(item_rd.weight);
            calc_cost        = ACC_W'(item_rd.cost);
            agent_we         = 1'b1;
            agent_waddr      = item_rd.agent;
            sums_in          = calc_sums_out;
            load_in          = '0;
            if (unassign_ff) begin
               item_we          = 1'b1;
               item_wdata.valid = 1'b0;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end else begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            calc_op           = CALC_ADD;
            calc_rec          = nrec_ff;
            agent_we          = 1'b1;
            sums_in           = calc_sums_out;
            load_in           = calc_rec_out.weight;
            item_we           = 1'b1;
            item_wdata.valid  = 1'b1;
            item_wdata.agent  = agent_ff;
            item_wdata.weight = weight_ff;
            item_wdata.cost   = cost_ff;
            rsp_valid_in      = 1'b1;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         sums_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sums_ff      <= sums_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff     <= type_in;
      item_ff     <= item_in;
      agent_ff    <= agent_in;
      item_ok_ff  <= item_ok_in;
      agent_ok_ff <= agent_ok_in;
      unassign_ff <= unassign_in;
      weight_ff   <= weight_in;
      cost_ff     <= cost_in;
      capv_ff     <= capv_in;
      nrec_ff     <= nrec_in;
      load_ff     <= load_in;
   end

   assign busy                   = (state_ff != S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_total_cost         = sums_ff.cost;
   assign rsp_total_weight       = sums_ff.weight;
   assign rsp_total_overcapacity = sums_ff.overcap;
   assign rsp_assigned_count     = sums_ff.count;
   assign rsp_feasible           = (sums_ff.overcap == '0);
   assign rsp_agent_load         = load_ff;

`ifndef SYNTHESIS
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while a request is in progress");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not hold the block busy");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a request being processed");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");
`endif

endmodule

`default_nettype wire
